// ----- design/zscore_normaliser_coefficients_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the normaliser coefficient block
// Shared helpers for concurrent checks clocked on clk; ZSN_ASSERT is off in reset.
// ----------------------------------------------------------------------------
`ifndef ZSCORE_NORMALISER_COEFFICIENTS_MACROS_SVH
`define ZSCORE_NORMALISER_COEFFICIENTS_MACROS_SVH

// Implication checked at every edge outside reset.
`define ZSN_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, also checked while reset is held.
`define ZSN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/zsn_pkg.sv -----
// ----------------------------------------------------------------------------
// zsn_pkg
// Types and constants shared by the normaliser coefficient modules.
// ----------------------------------------------------------------------------
package zsn_pkg;

  localparam int MAX_OBJECTS_DEF = 4096;

  localparam int SAMPLE_W = 16;
  localparam int TYPE_W   = 8;
  localparam int A_W      = 21;
  localparam int B_W      = 38;
  localparam int COUNT_W  = 13;
  localparam int STATUS_W = 2;
  localparam int ENG_W    = 64;

  localparam logic [TYPE_W-1:0] LIMIT_RESET = 8'd1;
  // (100 * 256)^2, the squared target spread in output units.
  localparam logic [ENG_W-1:0] TARGET_SQ = 64'd655360000;
  localparam logic [A_W-1:0]   A_MAX     = 21'h1FFFFF;
  localparam logic [A_W-1:0]   A_FLAT    = 21'd100;
  localparam logic [A_W-1:0]   A_SMALL   = 21'd1;

  localparam logic [STATUS_W-1:0] ST_NORMAL   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_FEW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FLAT     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

  typedef enum logic [2:0] {
    S_ACC,
    S_CHECK,
    S_GO,
    S_RUN,
    S_DZ,
    S_FIN
  } state_t;

  // Steps of the per-set computation, each one pass of the shared engine.
  typedef enum logic [2:0] {
    PH_NQ,    // n * Q
    PH_SS,    // |S| * |S|
    PH_NN1,   // n * (n - 1)
    PH_K,     // target^2 * n * (n - 1)
    PH_DIV,   // K / D
    PH_SQRT,  // floor(sqrt(K / D))
    PH_MAG,   // |S| * A
    PH_DIVN   // |S| * A / n
  } phase_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } op_t;

  typedef struct packed {
    logic   accept;
    logic   start;
    phase_t phase;
    logic   set_flat;
    logic   load_out;
  } cmd_t;

  typedef struct packed {
    logic eng_done;
    logic n_lt2;
    logic d_zero;
    logic out_free;
  } sts_t;

endpackage

// ----- design/zsn_ctrl.sv -----
// ----------------------------------------------------------------------------
// zsn_ctrl
// Sequencer: accepts items, then walks the per-set steps on the datapath.
// ----------------------------------------------------------------------------
module zsn_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  logic           in_tlast,
  output logic           in_tready,
  output zsn_pkg::cmd_t  cmd,
  input  zsn_pkg::sts_t  sts
);

  zsn_pkg::state_t state_r, state_nxt;
  zsn_pkg::phase_t phase_r, phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= zsn_pkg::S_ACC;
      phase_r <= zsn_pkg::PH_NQ;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    in_tready    = 1'b0;
    cmd.accept   = 1'b0;
    cmd.start    = 1'b0;
    cmd.phase    = phase_r;
    cmd.set_flat = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      zsn_pkg::S_ACC: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid && in_tlast) begin
          state_nxt = zsn_pkg::S_CHECK;
        end
      end
      zsn_pkg::S_CHECK: begin
        phase_nxt = zsn_pkg::PH_NQ;
        state_nxt = sts.n_lt2 ? zsn_pkg::S_FIN : zsn_pkg::S_GO;
      end
      zsn_pkg::S_GO: begin
        cmd.start = 1'b1;
        state_nxt = zsn_pkg::S_RUN;
      end
      zsn_pkg::S_RUN: begin
        if (sts.eng_done) begin
          state_nxt = zsn_pkg::S_GO;
          unique case (phase_r)
            zsn_pkg::PH_NQ:   phase_nxt = zsn_pkg::PH_SS;
            zsn_pkg::PH_SS:   state_nxt = zsn_pkg::S_DZ;
            zsn_pkg::PH_NN1:  phase_nxt = zsn_pkg::PH_K;
            zsn_pkg::PH_K:    phase_nxt = zsn_pkg::PH_DIV;
            zsn_pkg::PH_DIV:  phase_nxt = zsn_pkg::PH_SQRT;
            zsn_pkg::PH_SQRT: phase_nxt = zsn_pkg::PH_MAG;
            zsn_pkg::PH_MAG:  phase_nxt = zsn_pkg::PH_DIVN;
            zsn_pkg::PH_DIVN: state_nxt = zsn_pkg::S_FIN;
            default:          state_nxt = zsn_pkg::S_FIN;
          endcase
        end
      end
      zsn_pkg::S_DZ: begin
        // With no spread the scale is fixed and the root steps are skipped.
        cmd.set_flat = sts.d_zero;
        phase_nxt    = sts.d_zero ? zsn_pkg::PH_MAG : zsn_pkg::PH_NN1;
        state_nxt    = zsn_pkg::S_GO;
      end
      zsn_pkg::S_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = zsn_pkg::S_ACC;
        end
      end
      default: state_nxt = zsn_pkg::S_ACC;
    endcase
  end

endmodule

// ----- design/zsn_datapath.sv -----
// ----------------------------------------------------------------------------
// zsn_datapath
// Running statistics, the shared multiply/divide/root engine and the
// output register.
// ----------------------------------------------------------------------------
module zsn_datapath #(
  parameter int MAX_OBJECTS = zsn_pkg::MAX_OBJECTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [zsn_pkg::TYPE_W-1:0]     cfg_wdata,
  input  logic signed [zsn_pkg::SAMPLE_W-1:0] sample,
  input  logic [zsn_pkg::TYPE_W-1:0]     otype,
  input  logic                           last,
  input  zsn_pkg::cmd_t                  cmd,
  output zsn_pkg::sts_t                  sts,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [71:0]                    out_tdata,
  output logic [zsn_pkg::STATUS_W-1:0]   out_tuser
);

  localparam int CW   = $clog2(MAX_OBJECTS + 1);
  localparam int SW   = CW + zsn_pkg::SAMPLE_W;
  localparam int QW   = CW + 2 * zsn_pkg::SAMPLE_W - 2;
  localparam int EW   = zsn_pkg::ENG_W;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_OBJECTS);

  logic [zsn_pkg::TYPE_W-1:0] limit_r;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic [QW-1:0]        sq_r, sq_nxt;
  logic                 ovf_r, ovf_nxt;
  logic signed [2*zsn_pkg::SAMPLE_W-1:0] prod;

  // Snapshot of one finished set.
  logic [CW-1:0]  n_r;
  logic [EW-1:0]  sabs_r, q_r, nq_r, d_r, t_r;
  logic           neg_r, ovs_r;
  logic [zsn_pkg::A_W-1:0] a_r;

  // Engine state.
  zsn_pkg::op_t   op_r;
  logic [EW-1:0]  ex_r, ey_r;
  logic [EW:0]    eacc_r;
  logic [6:0]     ecnt_r;
  logic           busy_r, done_r;
  logic [EW:0]    rem_sh, root_try;

  logic           out_valid_r;
  logic [zsn_pkg::A_W-1:0] oa_r;
  logic [zsn_pkg::B_W-1:0] ob_r;
  logic [zsn_pkg::COUNT_W-1:0] on_r;
  logic [zsn_pkg::STATUS_W-1:0] ost_r;

  logic           n_lt2;
  logic [EW-1:0]  n64;
  logic [EW-1:0]  neg_mag;

  assign prod  = sample * sample;
  assign n_lt2 = (n_r < CW'(2));
  assign n64   = EW'(n_r);

  always_comb begin
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    sq_nxt  = sq_r;
    ovf_nxt = ovf_r;
    if (otype <= limit_r) begin
      if (cnt_r >= CNT_MAX) begin
        ovf_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CW'(1);
        sum_nxt = sum_r + SW'(sample);
        sq_nxt  = sq_r + QW'(unsigned'(prod));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= zsn_pkg::LIMIT_RESET;
      cnt_r   <= '0;
      sum_r   <= '0;
      sq_r    <= '0;
      ovf_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (cmd.accept) begin
        if (last) begin
          cnt_r <= '0;
          sum_r <= '0;
          sq_r  <= '0;
          ovf_r <= 1'b0;
        end else begin
          cnt_r <= cnt_nxt;
          sum_r <= sum_nxt;
          sq_r  <= sq_nxt;
          ovf_r <= ovf_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && last) begin
      n_r    <= cnt_nxt;
      neg_r  <= sum_nxt[SW-1];
      sabs_r <= sum_nxt[SW-1] ? EW'(unsigned'(-sum_nxt)) : EW'(unsigned'(sum_nxt));
      q_r    <= EW'(sq_nxt);
      ovs_r  <= ovf_nxt;
    end
  end

  // Shared engine: shift-add multiply, restoring divide, bitwise root.
  assign rem_sh   = {eacc_r[EW-1:0], ex_r[EW-1]};
  assign root_try = eacc_r + {1'b0, ey_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if ((op_r == zsn_pkg::OP_MUL) ? (ey_r == '0) : (ecnt_r == '0)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      eacc_r <= '0;
      case (cmd.phase)
        zsn_pkg::PH_NQ:   begin op_r <= zsn_pkg::OP_MUL; ex_r <= q_r; ey_r <= n64; end
        zsn_pkg::PH_SS:   begin op_r <= zsn_pkg::OP_MUL; ex_r <= sabs_r; ey_r <= sabs_r; end
        zsn_pkg::PH_NN1:  begin op_r <= zsn_pkg::OP_MUL; ex_r <= n64; ey_r <= n64 - EW'(1); end
        zsn_pkg::PH_K:    begin op_r <= zsn_pkg::OP_MUL; ex_r <= zsn_pkg::TARGET_SQ; ey_r <= t_r; end
        zsn_pkg::PH_DIV:  begin op_r <= zsn_pkg::OP_DIV; ex_r <= t_r; ey_r <= d_r; end
        zsn_pkg::PH_SQRT: begin
          op_r <= zsn_pkg::OP_SQRT;
          ex_r <= t_r;
          ey_r <= EW'(1) << (EW - 2);
        end
        zsn_pkg::PH_MAG:  begin op_r <= zsn_pkg::OP_MUL; ex_r <= sabs_r; ey_r <= EW'(a_r); end
        default:          begin op_r <= zsn_pkg::OP_DIV; ex_r <= t_r; ey_r <= n64; end
      endcase
      ecnt_r <= (cmd.phase == zsn_pkg::PH_SQRT) ? 7'd32 : 7'd64;
    end else if (busy_r) begin
      case (op_r)
        zsn_pkg::OP_MUL: begin
          if (ey_r[0]) begin
            eacc_r <= {1'b0, eacc_r[EW-1:0] + ex_r};
          end
          ex_r <= ex_r << 1;
          ey_r <= ey_r >> 1;
        end
        zsn_pkg::OP_DIV: begin
          if (ecnt_r != '0) begin
            if (rem_sh >= {1'b0, ey_r}) begin
              eacc_r <= rem_sh - {1'b0, ey_r};
              ex_r   <= {ex_r[EW-2:0], 1'b1};
            end else begin
              eacc_r <= rem_sh;
              ex_r   <= {ex_r[EW-2:0], 1'b0};
            end
            ecnt_r <= ecnt_r - 7'd1;
          end
        end
        default: begin
          if (ecnt_r != '0) begin
            if ({1'b0, ex_r} >= root_try) begin
              ex_r   <= ex_r - root_try[EW-1:0];
              eacc_r <= (eacc_r >> 1) + {1'b0, ey_r};
            end else begin
              eacc_r <= eacc_r >> 1;
            end
            ey_r   <= ey_r >> 2;
            ecnt_r <= ecnt_r - 7'd1;
          end
        end
      endcase
    end
  end

  // Step results, taken when the engine reports completion.
  always_ff @(posedge clk) begin
    if (cmd.set_flat) begin
      a_r <= zsn_pkg::A_FLAT;
    end
    if (done_r) begin
      case (cmd.phase)
        zsn_pkg::PH_NQ:   nq_r <= eacc_r[EW-1:0];
        zsn_pkg::PH_SS:   d_r  <= (nq_r >= eacc_r[EW-1:0]) ? nq_r - eacc_r[EW-1:0] : '0;
        zsn_pkg::PH_DIV:  t_r  <= ex_r;
        zsn_pkg::PH_SQRT: begin
          a_r <= (eacc_r[EW-1:0] > EW'(zsn_pkg::A_MAX)) ? zsn_pkg::A_MAX
                                                         : eacc_r[zsn_pkg::A_W-1:0];
        end
        zsn_pkg::PH_DIVN: t_r  <= ex_r;
        default:          t_r  <= eacc_r[EW-1:0];
      endcase
    end
  end

  assign neg_mag = -t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      on_r <= zsn_pkg::COUNT_W'(n_r);
      if (n_lt2) begin
        oa_r  <= zsn_pkg::A_SMALL;
        ob_r  <= '0;
        ost_r <= zsn_pkg::ST_TOO_FEW;
      end else begin
        oa_r  <= a_r;
        ob_r  <= neg_r ? t_r[zsn_pkg::B_W-1:0] : neg_mag[zsn_pkg::B_W-1:0];
        ost_r <= ovs_r ? zsn_pkg::ST_OVERFLOW
                       : ((d_r == '0) ? zsn_pkg::ST_FLAT : zsn_pkg::ST_NORMAL);
      end
    end
  end

  assign sts.eng_done = done_r;
  assign sts.n_lt2    = n_lt2;
  assign sts.d_zero   = (d_r == '0);
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {on_r, ob_r, oa_r};
  assign out_tuser  = ost_r;

endmodule

// ----- design/zscore_normaliser_coefficients.sv -----
// ----------------------------------------------------------------------------
// zscore_normaliser_coefficients
// Per-set mean/spread statistics and affine normaliser coefficients.
// ----------------------------------------------------------------------------
// Objects arrive on the in_ stream: in_tdata is the signed sample, in_tuser
// the object type, in_tlast closes a set. Objects whose type is at or below
// the limit written on cfg_ are counted. After the object marked last, the
// input stalls while one shared iterative engine works through the set. Each
// step is an issue state followed by its run: a multiply runs until its
// multiplier has shifted down to zero, a divide takes 64 steps and the root
// takes 32. A set with no spread skips the root steps, and a set of fewer
// than two objects skips the engine altogether.
// The result sits in an output register and input resumes as soon as it is
// loaded, so the next set accumulates while the receiver stalls; a second
// result waits until the first is taken.
// Reset clears the statistics, the output valid flag and sets the type
// limit to 1.
// ----------------------------------------------------------------------------
module zscore_normaliser_coefficients #(
  parameter int MAX_OBJECTS = zsn_pkg::MAX_OBJECTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,   // accept_type_limit
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // sample_value
  input  logic [7:0]  in_tuser,    // object_type
  input  logic        in_tlast,    // last_object
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,   // scale_a[20:0], offset_b[58:21], used_count[71:59]
  output logic [1:0]  out_tuser    // status
);

  zsn_pkg::cmd_t cmd;
  zsn_pkg::sts_t sts;

  zsn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  zsn_datapath #(
    .MAX_OBJECTS (MAX_OBJECTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .sample     (signed'(in_tdata)),
    .otype      (in_tuser),
    .last       (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- design/zsn_checker.sv -----
// ----------------------------------------------------------------------------
// zsn_checker
// Port-level checks on the result stream of the normaliser block.
// ----------------------------------------------------------------------------
`include "zscore_normaliser_coefficients_macros.svh"

module zsn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [1:0]  out_tuser
);

  `ZSN_ASSERT_NEXT(a_reset_idle, !rst_n, !out_tvalid, "result valid right after reset")
  `ZSN_ASSERT(a_hold, out_tvalid && !out_tready, ##1 (out_tvalid && $stable(out_tdata)), "stalled result changed")
  `ZSN_ASSERT(a_too_few, out_tvalid && out_tuser == zsn_pkg::ST_TOO_FEW, out_tdata[20:0] == 21'd1 && out_tdata[58:21] == 38'd0 && out_tdata[71:59] < 13'd2, "bad small-set result")
  `ZSN_ASSERT(a_flat, out_tvalid && out_tuser == zsn_pkg::ST_FLAT, out_tdata[20:0] == 21'd100, "flat set scale not 100")

endmodule

bind zscore_normaliser_coefficients zsn_checker u_zsn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- tb/zscore_normaliser_coefficients_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Normaliser coefficient checker
// This module watches the object stream and the result stream. It keeps its
// own running statistics of each set and works out the expected coefficients
// when the set closes. Each result transfer is compared field by field with
// the oldest expected one.
// ----------------------------------------------------------------------------
module zscore_normaliser_coefficients_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic [7:0]  in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [zsn_pkg::A_W-1:0]      scale_a;
    logic [zsn_pkg::B_W-1:0]      offset_b;
    logic [zsn_pkg::COUNT_W-1:0]  used_count;
    logic [zsn_pkg::STATUS_W-1:0] status;
  } coeff_t;

  coeff_t        coeff_queue[$];
  logic [7:0]    type_limit;
  int unsigned   obj_count;
  longint        value_sum;
  longint unsigned square_sum;
  bit            dropped;

  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 64'd4294967295;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (mid * mid <= x) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic coeff_t set_coefficients();
    coeff_t c;
    longint unsigned n, a, mag, nq, ss, d, k, sabs;
    longint b;
    n = obj_count;
    a = 1;
    b = 0;
    c.status = zsn_pkg::ST_NORMAL;
    if (n < 2) begin
      c.status = zsn_pkg::ST_TOO_FEW;
    end else begin
      sabs = value_sum < 0 ? -value_sum : value_sum;
      nq = n * square_sum;
      ss = sabs * sabs;
      d = nq >= ss ? nq - ss : 0;
      if (d == 0) begin
        a = 100;
        c.status = zsn_pkg::ST_FLAT;
      end else begin
        k = zsn_pkg::TARGET_SQ * (n * (n - 1));
        a = floor_root(k / d);
        if (a > zsn_pkg::A_MAX) a = zsn_pkg::A_MAX;
      end
      mag = (sabs * a) / n;
      b = value_sum < 0 ? longint'(mag) : -longint'(mag);
      if (dropped) c.status = zsn_pkg::ST_OVERFLOW;
    end
    c.scale_a = a[zsn_pkg::A_W-1:0];
    c.offset_b = b[zsn_pkg::B_W-1:0];
    c.used_count = n[zsn_pkg::COUNT_W-1:0];
    return c;
  endfunction

  assign pending_count = coeff_queue.size();

  always @(posedge clk) begin
    coeff_t got, want;
    if (!rst_n) begin
      type_limit <= zsn_pkg::LIMIT_RESET;
      obj_count = 0;
      value_sum = 0;
      square_sum = 0;
      dropped = 0;
      fail_count <= 0;
    end else begin
      if (cfg_we) type_limit <= cfg_wdata;
      if (in_tvalid && in_tready) begin
        if (in_tuser <= type_limit) begin
          if (obj_count >= zsn_pkg::MAX_OBJECTS_DEF) begin
            dropped = 1;
          end else begin
            obj_count++;
            value_sum += longint'($signed(in_tdata));
            square_sum += longint'($signed(in_tdata)) * longint'($signed(in_tdata));
          end
        end
        if (in_tlast) begin
          coeff_queue.push_back(set_coefficients());
          obj_count = 0;
          value_sum = 0;
          square_sum = 0;
          dropped = 0;
        end
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata[20:0], out_tdata[58:21], out_tdata[71:59], out_tuser};
        if (coeff_queue.size() == 0) begin
          $error("result transfer with no expected result");
          fail_count <= fail_count + 1;
        end else begin
          want = coeff_queue.pop_front();
          if (got != want) begin
            fail_count <= fail_count + 1;
            if (got.scale_a != want.scale_a)
              $error("scale_a expected %0d got %0d", want.scale_a, got.scale_a);
            if (got.offset_b != want.offset_b)
              $error("offset_b expected %0d got %0d", $signed(want.offset_b),
                     $signed(got.offset_b));
            if (got.used_count != want.used_count)
              $error("used_count expected %0d got %0d", want.used_count, got.used_count);
            if (got.status != want.status)
              $error("status expected %0d got %0d", want.status, got.status);
          end
        end
      end
    end
  end
endmodule

// ----- tb/zscore_normaliser_coefficients_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Normaliser coefficient testbench
// This top drives object sets of random length and content under a set of
// type limits, with random gaps on both streams. The checker beside the block
// predicts and compares, and this module prints the verdict.
// ----------------------------------------------------------------------------
module zscore_normaliser_coefficients_test;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [7:0]  cfg_wdata = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [15:0] in_tdata = 0;
  logic [7:0]  in_tuser = 0;
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;
  int          fail_count;
  int          pending_count;
  int          cycle_count = 0;
  bit          calm = 0;
  int          out_gap = 0;

  localparam int CYCLE_LIMIT = 3000000;

  always #10 clk = ~clk;

  zscore_normaliser_coefficients u_top (.*);
  zscore_normaliser_coefficients_checker u_check (.*);

  // Receiver side: random stall bursts until the calm stretch.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (!rst_n || calm) begin
      out_tready <= 1;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_tready <= 0;
    end else if ($urandom_range(0, 5) == 0) begin
      out_gap <= $urandom_range(1, 14) - 1;
      out_tready <= 0;
    end else begin
      out_tready <= 1;
    end
  end

  task automatic send_object(input logic [15:0] value, input logic [7:0] otype,
                             input logic last);
    int gap;
    bit took;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= value;
    in_tuser <= otype;
    in_tlast <= last;
    // Ready is sampled mid-cycle, where it has settled for the coming edge.
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic drain_results();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] limit);
    cfg_we <= 1;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // One set with random values; the spread of values varies per set.
  task automatic send_set(input int length, input logic [7:0] limit);
    int i, span;
    logic [15:0] v;
    logic [7:0] t;
    span = $urandom_range(0, 3);
    for (i = 0; i < length; i++) begin
      case (span)
        0: v = 16'($urandom);
        1: v = 16'($urandom_range(0, 40) - 20);
        2: v = 16'(16'h8000 | $urandom_range(0, 3));
        default: v = 16'(16'h7FFF - $urandom_range(0, 3));
      endcase
      t = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, limit));
      send_object(v, t, i == length - 1);
    end
  endtask

  initial begin
    int items, i;
    logic [7:0] limit;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed sets with the reset limit.
    send_object(16'h1234, 8'd0, 1);                    // single object
    send_object(16'h7FFF, 8'd1, 0);
    send_object(16'h8000, 8'd1, 1);                    // extremes
    send_object(16'd5, 8'd255, 0);
    send_object(16'd5, 8'd1, 1);                       // one ignored, too few
    send_object(16'hFFF0, 8'd0, 0);
    send_object(16'hFFF0, 8'd1, 0);
    send_object(16'hFFF0, 8'd0, 1);                    // zero spread
    send_object(16'd3, 8'd0, 0);
    send_object(16'd9, 8'd0, 0);
    send_object(16'hFFFF, 8'd2, 1);                    // normal
    send_object(16'd0, 8'd2, 1);                       // empty set
    drain_results();

    // Count overflow: more objects than the set can keep, all equal then mixed.
    write_limit(8'd255);
    for (i = 0; i < 4100; i++)
      send_object(16'h0042, 8'($urandom), i == 4099);
    for (i = 0; i < 4098; i++)
      send_object(16'($urandom), 8'($urandom), i == 4097);
    drain_results();

    items = 0;
    while (items < 1950) begin
      case ($urandom_range(0, 3))
        0: limit = 8'd0;
        1: limit = 8'd255;
        default: limit = 8'($urandom);
      endcase
      write_limit(limit);
      repeat (6) begin
        i = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 40);
        send_set(i, limit);
        items += i;
      end
      if (items > 1500) calm = 1;
      drain_results();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
